[sv/ptc_pkg.sv]
// Shared types, constants and the word decode helper for the particle/triangle cull core.
`default_nettype none
package ptc_pkg;

  localparam int MAX_TRIANGLES = 1024;
  localparam int ADDR_BITS     = $clog2(MAX_TRIANGLES);
  localparam int TID_BITS      = 10;
  localparam int PID_BITS      = 20;
  localparam int CNT_BITS      = 11;
  localparam int WSEL_BITS     = 5;
  localparam int QDEPTH        = 4;
  localparam int QPTR_BITS     = $clog2(QDEPTH);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TEST  = 1'b1;

  localparam logic [2:0] REASON_NONE   = 3'd0;
  localparam logic [2:0] REASON_BOX    = 3'd1;
  localparam logic [2:0] REASON_VERTEX = 3'd2;
  localparam logic [2:0] REASON_PLANE  = 3'd3;
  localparam logic [2:0] REASON_EDGE   = 3'd4;

  localparam logic [CNT_BITS-1:0] MAX_COUNT = CNT_BITS'(MAX_TRIANGLES);

  typedef enum logic [2:0] {
    WK_NONE,
    WK_FLAGS,
    WK_BOX,
    WK_VID,
    WK_NORM,
    WK_OFS,
    WK_THR
  } wkind_t;

  typedef struct packed {
    wkind_t     kind;
    logic [3:0] sub;
  } wdec_t;

  typedef struct packed {
    logic                   is_test;
    logic                   range_ok;
    logic [TID_BITS-1:0]    tid;
    wkind_t                 kind;
    logic [3:0]             sub;
    logic [63:0]            value;
    logic signed [31:0]     px;
    logic signed [31:0]     py;
    logic signed [31:0]     pz;
    logic [PID_BITS-1:0]    pid;
  } cmd_t;

  typedef struct packed {
    logic [PID_BITS-1:0] pid;
    logic [TID_BITS-1:0] tid;
    logic [2:0]          reason;
    logic                plane_en;
    logic                edge_en;
  } meta_t;

  typedef struct packed {
    logic                accepted;
    logic [2:0]          reason;
    logic [PID_BITS-1:0] pid;
    logic [TID_BITS-1:0] tid;
  } res_t;

  // word select -> storage group and slot within it
  function automatic wdec_t decode_word(input logic [WSEL_BITS-1:0] w);
    wdec_t      d;
    logic [4:0] r;
    logic [1:0] s;
    logic [4:0] k;
    d.kind = WK_NONE;
    d.sub  = 4'd0;
    r = w - 5'd10;
    if (r < 5'd5)       s = 2'd0;
    else if (r < 5'd10) s = 2'd1;
    else if (r < 5'd15) s = 2'd2;
    else                s = 2'd3;
    k = r - 5'(s) * 5'd5;
    if (w == 5'd0) begin
      d.kind = WK_FLAGS;
    end else if (w <= 5'd6) begin
      d.kind = WK_BOX;
      d.sub  = 4'(w - 5'd1);
    end else if (w <= 5'd9) begin
      d.kind = WK_VID;
      d.sub  = 4'(w - 5'd7);
    end else if (w <= 5'd29) begin
      if (k < 5'd3) begin
        d.kind = WK_NORM;
        d.sub  = 4'(s) * 4'd3 + 4'(k);
      end else if (k == 5'd3) begin
        d.kind = WK_OFS;
        d.sub  = 4'(s);
      end else begin
        d.kind = WK_THR;
        d.sub  = 4'(s);
      end
    end
    return d;
  endfunction

endpackage
`default_nettype wire

[sv/ptc_front.sv]
// Front end: takes requests, decodes them and queues them for the back end.
`default_nettype none
module ptc_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_push,
  output logic                                   in_full,
  input  wire logic                              in_operation,
  input  wire logic [ptc_pkg::TID_BITS-1:0]      in_triangle_id,
  input  wire logic [ptc_pkg::WSEL_BITS-1:0]     in_word_select,
  input  wire logic signed [63:0]                in_word_value,
  input  wire logic signed [31:0]                in_pos_x,
  input  wire logic signed [31:0]                in_pos_y,
  input  wire logic signed [31:0]                in_pos_z,
  input  wire logic [ptc_pkg::PID_BITS-1:0]      in_particle_id,
  input  wire logic                              cfg_we,
  input  wire logic [ptc_pkg::CNT_BITS-1:0]      cfg_data,
  input  wire logic                              clearing,
  input  wire logic                              q_pop,
  output logic                                   q_valid,
  output ptc_pkg::cmd_t                          q_head
);

  logic [ptc_pkg::CNT_BITS-1:0]  count_r;
  logic [ptc_pkg::CNT_BITS-1:0]  limit;
  ptc_pkg::cmd_t                 q_mem_r [ptc_pkg::QDEPTH];
  logic [ptc_pkg::QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ptc_pkg::QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ptc_pkg::QPTR_BITS:0]   cnt_r, cnt_nxt;
  logic                          accept;
  ptc_pkg::cmd_t                 cmd;
  ptc_pkg::wdec_t                wd;

  assign in_full = (cnt_r == (ptc_pkg::QPTR_BITS+1)'(ptc_pkg::QDEPTH)) || clearing;
  assign accept  = in_push && !in_full;
  assign limit   = (count_r > ptc_pkg::MAX_COUNT) ? ptc_pkg::MAX_COUNT : count_r;

  always_comb begin
    wd           = ptc_pkg::decode_word(in_word_select);
    cmd.is_test  = (in_operation == ptc_pkg::OP_TEST);
    cmd.range_ok = ({1'b0, in_triangle_id} < limit);
    cmd.tid      = in_triangle_id;
    cmd.kind     = wd.kind;
    cmd.sub      = wd.sub;
    cmd.value    = in_word_value;
    cmd.px       = in_pos_x;
    cmd.py       = in_pos_y;
    cmd.pz       = in_pos_z;
    cmd.pid      = in_particle_id;
  end

  always_comb begin
    wr_ptr_nxt = accept ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (ptc_pkg::QPTR_BITS+1)'(accept) - (ptc_pkg::QPTR_BITS+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_we) count_r <= cfg_data;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) q_mem_r[wr_ptr_r] <= cmd;
  end

  assign q_valid = (cnt_r != '0);
  assign q_head  = q_mem_r[rd_ptr_r];

endmodule
`default_nettype wire

[sv/ptc_back.sv]
// Back end: record table, cull pipeline and result queue.
`default_nettype none
module ptc_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  wire ptc_pkg::cmd_t                q_head,
  output logic                              q_pop,
  output logic                              clearing,
  output logic                              out_empty,
  input  wire logic                         out_pop,
  output logic                              out_accepted,
  output logic [2:0]                        out_reject_reason,
  output logic [ptc_pkg::PID_BITS-1:0]      out_particle_id,
  output logic [ptc_pkg::TID_BITS-1:0]      out_triangle_id
);

  localparam int MT = ptc_pkg::MAX_TRIANGLES;

  // record table
  logic [2:0]                   flag_mem [MT];
  logic signed [31:0]           box_mem  [6][MT];
  logic [ptc_pkg::PID_BITS-1:0] vid_mem  [3][MT];
  logic signed [31:0]           norm_mem [12][MT];
  logic signed [31:0]           ofs_mem  [4][MT];
  logic signed [63:0]           thr_mem  [4][MT];

  logic                         clearing_r;
  logic [ptc_pkg::ADDR_BITS:0]  clr_cnt_r;

  logic                         adv;
  logic                         wr_en;
  logic [ptc_pkg::ADDR_BITS-1:0] addr;
  ptc_pkg::cmd_t                c;

  // stage 1: record words read out
  logic                         v1_r;
  logic [ptc_pkg::PID_BITS-1:0] pid1_r;
  logic [ptc_pkg::TID_BITS-1:0] tid1_r;
  logic                         rok1_r;
  logic signed [31:0]           pos1_r [3];
  logic [2:0]                   flg1_r;
  logic signed [31:0]           box1_r [6];
  logic [ptc_pkg::PID_BITS-1:0] vid1_r [3];
  logic signed [31:0]           norm1_r [12];
  logic signed [31:0]           ofs1_r [4];
  logic signed [63:0]           thr1_r [4];
  ptc_pkg::meta_t               meta1;
  logic                         box_ok, vhit;

  // stages 2..5
  logic                         v2_r, v3_r, v4_r, v5_r;
  ptc_pkg::meta_t               meta2_r, meta3_r, meta4_r, meta5_r;
  logic signed [63:0]           prod2_r [12];
  logic signed [31:0]           ofs2_r [4], ofs3_r [4];
  logic signed [63:0]           thr2_r [4], thr3_r [4], thr4_r [4], thr5_r [4];
  logic signed [65:0]           sum3_r [4];
  logic signed [31:0]           d4_r [4];
  logic signed [63:0]           sq5_r [4];
  logic [3:0]                   neg5_r;
  logic signed [66:0]           diff [4];

  // result queue
  ptc_pkg::res_t                ofifo_r [2];
  logic                         owr_r, ord_r;
  logic [1:0]                   ocnt_r;
  logic                         ofull;
  logic                         ofifo_push;
  ptc_pkg::res_t                res;

  assign clearing = clearing_r;
  assign ofull    = (ocnt_r == 2'd2);
  assign adv      = !ofull || out_pop;
  assign q_pop    = adv && q_valid && !clearing_r;
  assign c        = q_head;
  assign wr_en    = q_pop && !c.is_test;
  assign addr     = c.tid[ptc_pkg::ADDR_BITS-1:0];

  // flags: swept to zero after reset, one record a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == (ptc_pkg::ADDR_BITS+1)'(MT - 1)) clearing_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      flag_mem[clr_cnt_r[ptc_pkg::ADDR_BITS-1:0]] <= 3'd0;
    end else if (wr_en && c.kind == ptc_pkg::WK_FLAGS) begin
      flag_mem[addr] <= c.value[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (c.kind)
        ptc_pkg::WK_BOX:  box_mem[c.sub[2:0]][addr]  <= c.value[31:0];
        ptc_pkg::WK_VID:  vid_mem[c.sub[1:0]][addr]  <= c.value[ptc_pkg::PID_BITS-1:0];
        ptc_pkg::WK_NORM: norm_mem[c.sub][addr]      <= c.value[31:0];
        ptc_pkg::WK_OFS:  ofs_mem[c.sub[1:0]][addr]  <= c.value[31:0];
        ptc_pkg::WK_THR:  thr_mem[c.sub[1:0]][addr]  <= c.value;
        default: ;
      endcase
    end
  end

  // registered reads; held while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      flg1_r <= flag_mem[addr];
      for (int i = 0; i < 6; i++)  box1_r[i]  <= box_mem[i][addr];
      for (int i = 0; i < 3; i++)  vid1_r[i]  <= vid_mem[i][addr];
      for (int i = 0; i < 12; i++) norm1_r[i] <= norm_mem[i][addr];
      for (int i = 0; i < 4; i++)  ofs1_r[i]  <= ofs_mem[i][addr];
      for (int i = 0; i < 4; i++)  thr1_r[i]  <= thr_mem[i][addr];
      pid1_r    <= c.pid;
      tid1_r    <= c.tid;
      rok1_r    <= c.range_ok;
      pos1_r[0] <= c.px;
      pos1_r[1] <= c.py;
      pos1_r[2] <= c.pz;
    end
  end

  always_comb begin
    box_ok = 1'b1;
    vhit   = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (pos1_r[a] < box1_r[a] || pos1_r[a] > box1_r[a+3]) box_ok = 1'b0;
      if (vid1_r[a] == pid1_r) vhit = 1'b1;
    end
    meta1.pid      = pid1_r;
    meta1.tid      = tid1_r;
    meta1.plane_en = flg1_r[1];
    meta1.edge_en  = flg1_r[2];
    if (!rok1_r || !flg1_r[0] || !box_ok) meta1.reason = ptc_pkg::REASON_BOX;
    else if (vhit)                        meta1.reason = ptc_pkg::REASON_VERTEX;
    else                                  meta1.reason = ptc_pkg::REASON_NONE;
  end

  always_comb begin
    for (int s = 0; s < 4; s++) begin
      diff[s] = 67'(sum3_r[s] >>> 16) - 67'(ofs3_r[s]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // products of normals and position
      for (int i = 0; i < 12; i++) prod2_r[i] <= 64'(norm1_r[i]) * 64'(pos1_r[i % 3]);
      for (int s = 0; s < 4; s++) begin
        ofs2_r[s] <= ofs1_r[s];
        thr2_r[s] <= thr1_r[s];
        // exact Q32.32 dot product
        sum3_r[s] <= 66'(prod2_r[3*s]) + 66'(prod2_r[3*s+1]) + 66'(prod2_r[3*s+2]);
        ofs3_r[s] <= ofs2_r[s];
        thr3_r[s] <= thr2_r[s];
        // floor to Q16.16, subtract offset, saturate
        if (diff[s][66:31] != {36{diff[s][66]}})
          d4_r[s] <= diff[s][66] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
          d4_r[s] <= diff[s][31:0];
        thr4_r[s] <= thr3_r[s];
        sq5_r[s]  <= 64'(d4_r[s]) * 64'(d4_r[s]);
        neg5_r[s] <= d4_r[s][31];
        thr5_r[s] <= thr4_r[s];
      end
      meta2_r <= meta1;
      meta3_r <= meta2_r;
      meta4_r <= meta3_r;
      meta5_r <= meta4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= q_pop && c.is_test;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_comb begin
    logic edge_rej;
    edge_rej = 1'b0;
    for (int s = 1; s < 4; s++) begin
      if (neg5_r[s] && sq5_r[s] > thr5_r[s]) edge_rej = 1'b1;
    end
    res.pid = meta5_r.pid;
    res.tid = meta5_r.tid;
    if (meta5_r.reason != ptc_pkg::REASON_NONE)       res.reason = meta5_r.reason;
    else if (meta5_r.plane_en && sq5_r[0] > thr5_r[0]) res.reason = ptc_pkg::REASON_PLANE;
    else if (meta5_r.edge_en && edge_rej)             res.reason = ptc_pkg::REASON_EDGE;
    else                                              res.reason = ptc_pkg::REASON_NONE;
    res.accepted = (res.reason == ptc_pkg::REASON_NONE);
  end

  assign ofifo_push = adv && v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= 1'b0;
      ord_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (ofifo_push) owr_r <= ~owr_r;
      if (out_pop && !out_empty) ord_r <= ~ord_r;
      ocnt_r <= ocnt_r + 2'(ofifo_push) - 2'(out_pop && !out_empty);
    end
  end

  always_ff @(posedge clk) begin
    if (ofifo_push) ofifo_r[owr_r] <= res;
  end

  assign out_empty         = (ocnt_r == 2'd0);
  assign out_accepted      = ofifo_r[ord_r].accepted;
  assign out_reject_reason = ofifo_r[ord_r].reason;
  assign out_particle_id   = ofifo_r[ord_r].pid;
  assign out_triangle_id   = ofifo_r[ord_r].tid;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (ofull && !out_pop) |-> !ofifo_push) else $error("result queue overflow");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !q_pop) else $error("request taken during clear");
  a_ocnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r != 2'd3) else $error("result count out of range");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v5_r)) else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

[sv/particle_triangle_candidate_cull_core.sv]
// Top level of the particle/triangle broad-phase cull core.
// Input channel: push/full queue. Each request either writes one word of a
// triangle record (operation 0) or tests a particle against a triangle
// (operation 1). A request is taken at a clock edge with in_push high and
// in_full low. Tests give one result each, in order; writes give none.
// Result channel: out_empty/out_pop queue; the oldest result is on the out_
// ports while out_empty is low and leaves at an edge with out_pop high.
// cfg_we/cfg_data write triangle_count; write it only while idle.
// Throughput: one request per cycle while the cull pipeline is not stalled.
// A test goes through the request queue, the cull pipeline and the result queue.
// The pipeline freezes when the two-entry result queue is full and not
// popped; the four-entry request queue then fills and raises in_full.
// Reset: synchronous, active low. After reset a pass over every record clears the
// record valid flags; in_full stays high until it is done. Other record
// words are undefined until written.
`default_nettype none
module particle_triangle_candidate_cull_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic                          in_operation,
  input  wire logic [ptc_pkg::TID_BITS-1:0]  in_triangle_id,
  input  wire logic [ptc_pkg::WSEL_BITS-1:0] in_word_select,
  input  wire logic signed [63:0]            in_word_value,
  input  wire logic signed [31:0]            in_pos_x,
  input  wire logic signed [31:0]            in_pos_y,
  input  wire logic signed [31:0]            in_pos_z,
  input  wire logic [ptc_pkg::PID_BITS-1:0]  in_particle_id,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic                               out_accepted,
  output logic [2:0]                         out_reject_reason,
  output logic [ptc_pkg::PID_BITS-1:0]       out_particle_id,
  output logic [ptc_pkg::TID_BITS-1:0]       out_triangle_id,
  input  wire logic                          cfg_we,
  input  wire logic [ptc_pkg::CNT_BITS-1:0]  cfg_data
);

  logic          clearing;
  logic          q_pop;
  logic          q_valid;
  ptc_pkg::cmd_t q_head;

  ptc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_operation   (in_operation),
    .in_triangle_id (in_triangle_id),
    .in_word_select (in_word_select),
    .in_word_value  (in_word_value),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_particle_id (in_particle_id),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .clearing       (clearing),
    .q_pop          (q_pop),
    .q_valid        (q_valid),
    .q_head         (q_head)
  );

  ptc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .clearing          (clearing),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_accepted      (out_accepted),
    .out_reject_reason (out_reject_reason),
    .out_particle_id   (out_particle_id),
    .out_triangle_id   (out_triangle_id)
  );

endmodule
`default_nettype wire
